@@ src/cubic_four_point_interpolation_top_assert.svh @@
// Assertion macros used by the cubic four-point interpolation RTL.
// Included by the top level only; no other dependencies.
`ifndef CUBIC_FOUR_POINT_INTERPOLATION_TOP_ASSERT_SVH
`define CUBIC_FOUR_POINT_INTERPOLATION_TOP_ASSERT_SVH

// same-cycle implication
`define CFP_ASSERT_IMPLY(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("cfp: same-cycle check failed");

// next-cycle implication
`define CFP_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("cfp: next-cycle check failed");

`endif

@@ src/cfp_pkg.sv @@
// Shared types and constants for the cubic four-point interpolation block.
// No dependencies.
`default_nettype none

package cfp_pkg;

    localparam int CHUNK = 32;

    typedef logic [1:0] status_t;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_COINC = 2'd1;
    localparam status_t ST_SAT   = 2'd2;

    typedef struct packed {
        logic valid;
        logic coinc;
    } tag_t;

endpackage

`default_nettype wire

@@ src/cfp_front.sv @@
// Front end: abscissa differences, coincidence check, magnitudes and term signs.
// Two register stages; no package dependencies.
`default_nettype none

module cfp_front #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic signed [DATA_WIDTH-1:0] query_x,
    input  wire logic signed [DATA_WIDTH-1:0] px [4],
    input  wire logic signed [DATA_WIDTH-1:0] py [4],
    output logic             [DATA_WIDTH-1:0] ymag [4],
    output logic             [DATA_WIDTH:0]   nmag [4][3],
    output logic             [DATA_WIDTH:0]   dmag [4][3],
    output logic                              neg [4],
    output logic                              coinc
);

    localparam int DW = DATA_WIDTH;
    localparam int XW = DATA_WIDTH + 1;

    logic signed [XW-1:0] dq_reg [4];
    logic signed [XW-1:0] dx_reg [4][3];
    logic signed [DW-1:0] y_reg [4];
    logic                 coinc1_reg;

    logic [DW-1:0] ymag_reg [4];
    logic [XW-1:0] nmag_reg [4][3];
    logic [XW-1:0] dmag_reg [4][3];
    logic          neg_reg [4];
    logic          coinc2_reg;

    function automatic logic [XW-1:0] mag_x(input logic [XW-1:0] v);
        return v[XW-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [DW-1:0] mag_y(input logic [DW-1:0] v);
        return v[DW-1] ? (~v + 1'b1) : v;
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 4; j++)
            begin
                dq_reg[j] <= XW'(query_x) - XW'(px[j]);
                y_reg[j]  <= py[j];
            end
            for (int i = 0; i < 4; i++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    dx_reg[i][k] <= XW'(px[i]) - XW'(px[(k < i) ? k : k + 1]);
                end
            end
            coinc1_reg <= (px[0] == px[1]) || (px[0] == px[2]) || (px[0] == px[3]) ||
                          (px[1] == px[2]) || (px[1] == px[3]) || (px[2] == px[3]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                ymag_reg[i] <= mag_y(y_reg[i]);
                neg_reg[i]  <= y_reg[i][DW-1]
                             ^ dq_reg[(0 < i) ? 0 : 1][XW-1] ^ dx_reg[i][0][XW-1]
                             ^ dq_reg[(1 < i) ? 1 : 2][XW-1] ^ dx_reg[i][1][XW-1]
                             ^ dq_reg[(2 < i) ? 2 : 3][XW-1] ^ dx_reg[i][2][XW-1];
                for (int k = 0; k < 3; k++)
                begin
                    nmag_reg[i][k] <= mag_x(dq_reg[(k < i) ? k : k + 1]);
                    dmag_reg[i][k] <= mag_x(dx_reg[i][k]);
                end
            end
            coinc2_reg <= coinc1_reg;
        end
    end

    assign ymag  = ymag_reg;
    assign nmag  = nmag_reg;
    assign dmag  = dmag_reg;
    assign neg   = neg_reg;
    assign coinc = coinc2_reg;

endmodule

`default_nettype wire

@@ src/cfp_mul.sv @@
// Two-stage unsigned multiplier built from 32x32 partial products.
// Depends on cfp_pkg for the chunk width.
`default_nettype none

module cfp_mul
    import cfp_pkg::*;
#(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [AW-1:0]    a,
    input  wire logic [BW-1:0]    b,
    output logic      [AW+BW-1:0] p
);

    localparam int NA = (AW + CHUNK - 1) / CHUNK;
    localparam int NB = (BW + CHUNK - 1) / CHUNK;
    localparam int EA = NA * CHUNK;
    localparam int EB = NB * CHUNK;
    localparam int SW = EA + EB;
    localparam int PW = AW + BW;

    logic [EA-1:0]        a_ext;
    logic [EB-1:0]        b_ext;
    logic [2*CHUNK-1:0]   pp_reg [NA][NB];
    logic [SW-1:0]        acc;
    logic [PW-1:0]        p_reg;

    assign a_ext = EA'(a);
    assign b_ext = EB'(b);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NA; i++)
            begin
                for (int j = 0; j < NB; j++)
                begin
                    pp_reg[i][j] <= (2*CHUNK)'(a_ext[i*CHUNK +: CHUNK])
                                  * (2*CHUNK)'(b_ext[j*CHUNK +: CHUNK]);
                end
            end
        end
    end

    always_comb
    begin
        acc = '0;
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                acc = acc + (SW'(pp_reg[i][j]) << (CHUNK * (i + j)));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= acc[PW-1:0];
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

@@ src/cfp_prod.sv @@
// One lane's numerator and denominator product chain, six register stages.
// Depends on cfp_mul.
`default_nettype none

module cfp_prod #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                      clk,
    input  wire logic                      en,
    input  wire logic [DATA_WIDTH-1:0]     ymag,
    input  wire logic [DATA_WIDTH:0]       nmag [3],
    input  wire logic [DATA_WIDTH:0]       dmag [3],
    output logic      [4*DATA_WIDTH+2:0]   num,
    output logic      [3*DATA_WIDTH+2:0]   den
);

    localparam int DW   = DATA_WIDTH;
    localparam int XW   = DATA_WIDTH + 1;
    localparam int M1W  = DW + XW;
    localparam int M2W  = M1W + XW;
    localparam int NW   = M2W + XW;
    localparam int D1W  = 2 * XW;
    localparam int DENW = 3 * XW;

    logic [XW-1:0]   b_dly_reg [2];
    logic [XW-1:0]   c_dly_reg [4];
    logic [XW-1:0]   e_dly_reg [2];
    logic [DENW-1:0] den_dly_reg [2];

    logic [M1W-1:0]  m1;
    logic [M2W-1:0]  m2;
    logic [NW-1:0]   m3;
    logic [D1W-1:0]  d1;
    logic [DENW-1:0] d2;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_dly_reg[0]   <= nmag[1];
            b_dly_reg[1]   <= b_dly_reg[0];
            e_dly_reg[0]   <= dmag[2];
            e_dly_reg[1]   <= e_dly_reg[0];
            c_dly_reg[0]   <= nmag[2];
            for (int s = 1; s < 4; s++)
            begin
                c_dly_reg[s] <= c_dly_reg[s-1];
            end
            den_dly_reg[0] <= d2;
            den_dly_reg[1] <= den_dly_reg[0];
        end
    end

    cfp_mul #(.AW(DW), .BW(XW)) u_m1 (
        .clk (clk), .en (en), .a (ymag), .b (nmag[0]), .p (m1)
    );

    cfp_mul #(.AW(M1W), .BW(XW)) u_m2 (
        .clk (clk), .en (en), .a (m1), .b (b_dly_reg[1]), .p (m2)
    );

    cfp_mul #(.AW(M2W), .BW(XW)) u_m3 (
        .clk (clk), .en (en), .a (m2), .b (c_dly_reg[3]), .p (m3)
    );

    cfp_mul #(.AW(XW), .BW(XW)) u_d1 (
        .clk (clk), .en (en), .a (dmag[0]), .b (dmag[1]), .p (d1)
    );

    cfp_mul #(.AW(D1W), .BW(XW)) u_d2 (
        .clk (clk), .en (en), .a (d1), .b (e_dly_reg[1]), .p (d2)
    );

    assign num = m3;
    assign den = den_dly_reg[1];

endmodule

`default_nettype wire

@@ src/cfp_div.sv @@
// Four-lane restoring divider, one quotient bit per register stage.
// Depends on cfp_pkg for the pipeline tag.
`default_nettype none

module cfp_div
    import cfp_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      en,
    input  wire tag_t                      tag_in,
    input  wire logic [4*DATA_WIDTH+2:0]   num_in [4],
    input  wire logic [3*DATA_WIDTH+2:0]   den_in [4],
    input  wire logic                      neg_in [4],
    output tag_t                           tag_out,
    output logic      [4*DATA_WIDTH+2:0]   quo [4],
    output logic      [3*DATA_WIDTH+2:0]   rem [4],
    output logic      [3*DATA_WIDTH+2:0]   den [4],
    output logic                           neg [4]
);

    localparam int NW   = 4 * DATA_WIDTH + 3;
    localparam int DENW = 3 * DATA_WIDTH + 3;

    tag_t            tag_reg [NW];
    logic [NW-1:0]   nq_reg  [4][NW];
    logic [DENW-1:0] rem_reg [4][NW];
    logic [DENW-1:0] den_reg [4][NW];
    logic            neg_reg [4][NW];

    for (genvar s = 0; s < NW; s++)
    begin : g_stage
        if (s == 0)
        begin : g_tag_first
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    tag_reg[s] <= '0;
                end
                else if (en)
                begin
                    tag_reg[s] <= tag_in;
                end
            end
        end
        else
        begin : g_tag_rest
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    tag_reg[s] <= '0;
                end
                else if (en)
                begin
                    tag_reg[s] <= tag_reg[s-1];
                end
            end
        end

        for (genvar l = 0; l < 4; l++)
        begin : g_lane
            logic [NW-1:0]   nq_prev;
            logic [DENW-1:0] rem_prev;
            logic [DENW-1:0] den_prev;
            logic            neg_prev;
            logic [DENW:0]   trial;
            logic            ge;

            if (s == 0)
            begin : g_first
                assign nq_prev  = num_in[l];
                assign rem_prev = '0;
                assign den_prev = den_in[l];
                assign neg_prev = neg_in[l];
            end
            else
            begin : g_rest
                assign nq_prev  = nq_reg[l][s-1];
                assign rem_prev = rem_reg[l][s-1];
                assign den_prev = den_reg[l][s-1];
                assign neg_prev = neg_reg[l][s-1];
            end

            assign trial = {rem_prev, nq_prev[NW-1]};
            assign ge    = trial >= {1'b0, den_prev};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    nq_reg[l][s]  <= {nq_prev[NW-2:0], ge};
                    rem_reg[l][s] <= ge ? DENW'(trial - {1'b0, den_prev}) : trial[DENW-1:0];
                    den_reg[l][s] <= den_prev;
                    neg_reg[l][s] <= neg_prev;
                end
            end
        end
    end

    assign tag_out = tag_reg[NW-1];

    for (genvar l = 0; l < 4; l++)
    begin : g_out
        assign quo[l] = nq_reg[l][NW-1];
        assign rem[l] = rem_reg[l][NW-1];
        assign den[l] = den_reg[l][NW-1];
        assign neg[l] = neg_reg[l][NW-1];
    end

endmodule

`default_nettype wire

@@ src/cubic_four_point_interpolation_top.sv @@
// Top level of the four-point cubic (Lagrange) interpolator.
// Depends on cfp_pkg, cfp_front, cfp_prod, cfp_div and the assertion macro header.
//
// Usage:
//   Input channel item_valid/item_stall carries the query abscissa and four
//   sample points; a transfer happens when item_valid is high and item_stall low.
//   Output channel result_valid/result_stall carries interp_y and status, one
//   result per input item, in order.
//   The pipeline has two front stages, six product stages, one divider stage
//   per numerator bit (4*DATA_WIDTH+3), and five stages of rounding, summing
//   and saturation.
//   Throughput is one item per cycle while the output is not stalled; the
//   pipeline is fully registered and the long restoring divider sets the latency.
//   When the receiver stalls while a result is pending, the whole pipeline
//   holds and item_stall rises in the same cycle; nothing is dropped or repeated.
//   Reset clears every valid bit; payload registers keep whatever they held.
//   status: 0 ok, 1 two abscissae coincide (interp_y is zero), 2 saturated.
`default_nettype none
`include "cubic_four_point_interpolation_top_assert.svh"

module cubic_four_point_interpolation_top
    import cfp_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         item_valid,
    output logic                              item_stall,
    input  wire logic signed [DATA_WIDTH-1:0] query_x,
    input  wire logic signed [DATA_WIDTH-1:0] point_x1,
    input  wire logic signed [DATA_WIDTH-1:0] point_x2,
    input  wire logic signed [DATA_WIDTH-1:0] point_x3,
    input  wire logic signed [DATA_WIDTH-1:0] point_x4,
    input  wire logic signed [DATA_WIDTH-1:0] point_y1,
    input  wire logic signed [DATA_WIDTH-1:0] point_y2,
    input  wire logic signed [DATA_WIDTH-1:0] point_y3,
    input  wire logic signed [DATA_WIDTH-1:0] point_y4,
    output logic                              result_valid,
    input  wire logic                         result_stall,
    output logic signed [DATA_WIDTH-1:0]      interp_y,
    output status_t                           status
);

    localparam int DW   = DATA_WIDTH;
    localparam int XW   = DATA_WIDTH + 1;
    localparam int NW   = 4 * DATA_WIDTH + 3;
    localparam int DENW = 3 * DATA_WIDTH + 3;
    localparam int TW   = NW + 2;
    localparam int SW   = TW + 2;

    localparam logic signed [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};

    logic adv;

    logic signed [DW-1:0] px [4];
    logic signed [DW-1:0] py [4];

    logic          vf_reg [2];
    logic [DW-1:0] ymag_f [4];
    logic [XW-1:0] nmag_f [4][3];
    logic [XW-1:0] dmag_f [4][3];
    logic          neg_f [4];
    logic          coinc_f;

    tag_t          ptag_reg [6];
    logic [3:0]    pneg_reg [6];
    logic [NW-1:0] num_p [4];
    logic [DENW-1:0] den_p [4];
    logic          neg_p [4];

    tag_t            dtag;
    logic [NW-1:0]   quo_d [4];
    logic [DENW-1:0] rem_d [4];
    logic [DENW-1:0] den_d [4];
    logic            neg_d [4];

    logic               up [4];
    tag_t               tag1_reg;
    logic [NW:0]        mag1_reg [4];
    logic               neg1_reg [4];
    tag_t               tag2_reg;
    logic signed [TW-1:0] term_reg [4];
    tag_t               tag3_reg;
    logic signed [TW:0] pair_reg [2];
    tag_t               tag4_reg;
    logic signed [SW-1:0] sum_reg;
    logic [SW-DW:0]     sum_hi;
    logic               sat;

    logic                 result_valid_reg;
    logic signed [DW-1:0] interp_y_reg;
    status_t              status_reg;

    assign adv        = !(result_valid_reg && result_stall);
    assign item_stall = !adv;

    assign px[0] = point_x1;
    assign px[1] = point_x2;
    assign px[2] = point_x3;
    assign px[3] = point_x4;
    assign py[0] = point_y1;
    assign py[1] = point_y2;
    assign py[2] = point_y3;
    assign py[3] = point_y4;

    cfp_front #(.DATA_WIDTH(DW)) u_front (
        .clk     (clk),
        .en      (adv),
        .query_x (query_x),
        .px      (px),
        .py      (py),
        .ymag    (ymag_f),
        .nmag    (nmag_f),
        .dmag    (dmag_f),
        .neg     (neg_f),
        .coinc   (coinc_f)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vf_reg[0] <= 1'b0;
            vf_reg[1] <= 1'b0;
            for (int s = 0; s < 6; s++)
            begin
                ptag_reg[s] <= '0;
            end
        end
        else if (adv)
        begin
            vf_reg[0]   <= item_valid;
            vf_reg[1]   <= vf_reg[0];
            ptag_reg[0] <= '{valid: vf_reg[1], coinc: coinc_f};
            for (int s = 1; s < 6; s++)
            begin
                ptag_reg[s] <= ptag_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pneg_reg[0] <= {neg_f[3], neg_f[2], neg_f[1], neg_f[0]};
            for (int s = 1; s < 6; s++)
            begin
                pneg_reg[s] <= pneg_reg[s-1];
            end
        end
    end

    for (genvar l = 0; l < 4; l++)
    begin : g_prod
        cfp_prod #(.DATA_WIDTH(DW)) u_prod (
            .clk  (clk),
            .en   (adv),
            .ymag (ymag_f[l]),
            .nmag (nmag_f[l]),
            .dmag (dmag_f[l]),
            .num  (num_p[l]),
            .den  (den_p[l])
        );
        assign neg_p[l] = pneg_reg[5][l];
    end

    cfp_div #(.DATA_WIDTH(DW)) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .tag_in  (ptag_reg[5]),
        .num_in  (num_p),
        .den_in  (den_p),
        .neg_in  (neg_p),
        .tag_out (dtag),
        .quo     (quo_d),
        .rem     (rem_d),
        .den     (den_d),
        .neg     (neg_d)
    );

    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            up[l] = {rem_d[l], 1'b0} >= {1'b0, den_d[l]};
        end
    end

    assign sum_hi = sum_reg[SW-1:DW-1];
    assign sat    = !((&sum_hi) || (~|sum_hi));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg         <= '0;
            tag2_reg         <= '0;
            tag3_reg         <= '0;
            tag4_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            tag1_reg         <= dtag;
            tag2_reg         <= tag1_reg;
            tag3_reg         <= tag2_reg;
            tag4_reg         <= tag3_reg;
            result_valid_reg <= tag4_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < 4; l++)
            begin
                mag1_reg[l] <= (NW+1)'(quo_d[l]) + (NW+1)'(up[l]);
                neg1_reg[l] <= neg_d[l];
                term_reg[l] <= neg1_reg[l] ? -TW'(mag1_reg[l]) : TW'(mag1_reg[l]);
            end
            pair_reg[0] <= (TW+1)'(term_reg[0]) + (TW+1)'(term_reg[1]);
            pair_reg[1] <= (TW+1)'(term_reg[2]) + (TW+1)'(term_reg[3]);
            sum_reg     <= SW'(pair_reg[0]) + SW'(pair_reg[1]);
            if (tag4_reg.coinc)
            begin
                interp_y_reg <= '0;
                status_reg   <= ST_COINC;
            end
            else if (sat)
            begin
                interp_y_reg <= sum_reg[SW-1] ? SAT_MIN : SAT_MAX;
                status_reg   <= ST_SAT;
            end
            else
            begin
                interp_y_reg <= sum_reg[DW-1:0];
                status_reg   <= ST_OK;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign interp_y     = interp_y_reg;
    assign status       = status_reg;

    `CFP_ASSERT_IMPLY(a_coinc_zero, clk, rst_n, result_valid_reg && status_reg == ST_COINC, interp_y_reg == '0)
    `CFP_ASSERT_IMPLY(a_sat_bound, clk, rst_n, result_valid_reg && status_reg == ST_SAT, interp_y_reg == SAT_MAX || interp_y_reg == SAT_MIN)
    `CFP_ASSERT_NEXT(a_stall_keeps_result, clk, rst_n, item_stall, result_valid_reg)

endmodule

`default_nettype wire

@@ tb/sv/cubic_four_point_interpolation_top_test.sv @@
// Self-checking testbench for cubic_four_point_interpolation_top: directed table, then
// random items under random idling and stalls, scored against an exact-width predictor.
// Depends on cfp_pkg and the RTL of cubic_four_point_interpolation_top.
`default_nettype none

module cubic_four_point_interpolation_top_test
    import cfp_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [31:0]  word_t;
    typedef logic signed [199:0] wide_t;

    typedef struct {
        word_t   y;
        status_t st;
    } interp_result_t;

    typedef struct {
        word_t   q;
        word_t   x [4];
        word_t   y [4];
        bit      typed;
        word_t   ey;
        status_t est;
    } stim_row_t;

    localparam word_t ONE  = 32'sh0001_0000;
    localparam word_t WMAX = 32'sh7FFF_FFFF;
    localparam word_t WMIN = 32'sh8000_0000;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    word_t   query_x;
    word_t   point_x1, point_x2, point_x3, point_x4;
    word_t   point_y1, point_y2, point_y3, point_y4;
    logic    result_valid;
    logic    result_stall;
    word_t   interp_y;
    status_t status;

    interp_result_t pending_results [$];
    stim_row_t      stim_table [$];
    int             error_count;
    bit             long_hold;

    cubic_four_point_interpolation_top #(.DATA_WIDTH(32)) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .query_x      (query_x),
        .point_x1     (point_x1),
        .point_x2     (point_x2),
        .point_x3     (point_x3),
        .point_x4     (point_x4),
        .point_y1     (point_y1),
        .point_y2     (point_y2),
        .point_y3     (point_y3),
        .point_y4     (point_y4),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .interp_y     (interp_y),
        .status       (status)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic interp_result_t lagrange_eval(word_t q, word_t x [4], word_t y [4]);
        interp_result_t r;
        wide_t          num, den, an, ad, quo, rem, acc;
        bit             neg;
        r.y  = '0;
        r.st = ST_OK;
        for (int i = 0; i < 4; i++)
            for (int j = i + 1; j < 4; j++)
                if (x[i] == x[j])
                begin
                    r.st = ST_COINC;
                    return r;
                end
        acc = '0;
        for (int i = 0; i < 4; i++)
        begin
            num = wide_t'(y[i]);
            den = 1;
            for (int j = 0; j < 4; j++)
                if (j != i)
                begin
                    num = num * (wide_t'(q) - wide_t'(x[j]));
                    den = den * (wide_t'(x[i]) - wide_t'(x[j]));
                end
            neg = (num < 0) != (den < 0);
            an  = (num < 0) ? -num : num;
            ad  = (den < 0) ? -den : den;
            quo = an / ad;
            rem = an - quo * ad;
            if (2 * rem >= ad)
                quo = quo + 1;
            acc = neg ? acc - quo : acc + quo;
        end
        if (acc > wide_t'(WMAX))
        begin
            r.y  = WMAX;
            r.st = ST_SAT;
        end
        else if (acc < wide_t'(WMIN))
        begin
            r.y  = WMIN;
            r.st = ST_SAT;
        end
        else
            r.y = acc[31:0];
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH @%0t: %s", $time, what);
        error_count++;
    endtask

    task automatic add_row(word_t q, word_t x1, word_t x2, word_t x3, word_t x4,
                           word_t y1, word_t y2, word_t y3, word_t y4,
                           bit typed, word_t ey, status_t est);
        stim_row_t row;
        row.q = q;
        row.x[0] = x1; row.x[1] = x2; row.x[2] = x3; row.x[3] = x4;
        row.y[0] = y1; row.y[1] = y2; row.y[2] = y3; row.y[3] = y4;
        row.typed = typed;
        row.ey = ey;
        row.est = est;
        stim_table = {stim_table, row};
    endtask

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(stim_row_t row, int gap);
        interp_result_t e;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        query_x  <= row.q;
        point_x1 <= row.x[0]; point_x2 <= row.x[1];
        point_x3 <= row.x[2]; point_x4 <= row.x[3];
        point_y1 <= row.y[0]; point_y2 <= row.y[1];
        point_y3 <= row.y[2]; point_y4 <= row.y[3];
        do @(posedge clk); while (item_stall);
        if (row.typed)
        begin
            e.y  = row.ey;
            e.st = row.est;
        end
        else
            e = lagrange_eval(row.q, row.x, row.y);
        pending_results = {pending_results, e};
        @(negedge clk);
    endtask

    function automatic word_t near_word(int span);
        return word_t'($urandom_range(0, 2 * span)) - word_t'(span);
    endfunction

    function automatic stim_row_t random_row();
        stim_row_t row;
        int        mode;
        mode = $urandom_range(0, 9);
        row.typed = 1'b0;
        row.ey = '0;
        row.est = ST_OK;
        for (int k = 0; k < 4; k++)
        begin
            if (mode == 0)
            begin
                row.x[k] = $urandom;
                row.y[k] = $urandom;
            end
            else
            begin
                row.x[k] = near_word(8 * ONE);
                row.y[k] = ($urandom_range(0, 3) == 0) ? word_t'($urandom)
                                                       : near_word(100 * ONE);
            end
        end
        row.q = (mode == 0) ? word_t'($urandom) : near_word(12 * ONE);
        if (mode == 1)
            row.x[$urandom_range(0, 3)] = row.x[$urandom_range(0, 3)];
        if (mode == 2)
            row.q = row.x[$urandom_range(0, 3)];
        return row;
    endfunction

    initial
    begin
        error_count = 0;
        long_hold = 1'b0;
        rst_n = 1'b0;
        item_valid = 1'b0;
        query_x = '0;
        point_x1 = '0; point_x2 = '0; point_x3 = '0; point_x4 = '0;
        point_y1 = '0; point_y2 = '0; point_y3 = '0; point_y4 = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        add_row(0, 0, 0, 0, 0, WMAX, WMIN, 1, -1, 1, 0, ST_COINC);
        add_row(5, 3, 7, 5, 9, 11, 22, 33, 44, 1, 33, ST_OK);
        add_row(2 * ONE, ONE, 2 * ONE, 3 * ONE, 4 * ONE, 10 * ONE, -7 * ONE, 3, WMAX,
                1, -7 * ONE, ST_OK);
        add_row(WMIN, WMIN, WMAX, 0, 1, WMIN, WMAX, -1, 0, 1, WMIN, ST_OK);
        add_row(WMAX, WMIN, WMAX, 0, 1, 123, WMAX, -1, 0, 1, WMAX, ST_OK);
        add_row(1, WMIN, WMAX, 0, 1, WMIN, WMAX, -1, WMIN, 1, WMIN, ST_OK);
        add_row(WMAX, 0, ONE, 2 * ONE, 3 * ONE, 0, ONE, 8 * ONE, 27 * ONE, 0, 0, ST_OK);
        add_row(WMIN, 0, ONE, 2 * ONE, 3 * ONE, 0, ONE, 8 * ONE, 27 * ONE, 0, 0, ST_OK);
        add_row(WMAX, 0, 1, 2, 3, WMAX, WMIN, WMAX, WMIN, 0, 0, ST_OK);
        add_row(-ONE / 2, 0, ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE, 4 * ONE,
                0, 0, ST_OK);
        add_row(ONE / 3, 0, ONE, -ONE, 2 * ONE, -1, -1, -1, -1, 0, 0, ST_OK);
        add_row(7, 1, 2, 3, 4, 1, 0, 0, 1, 0, 0, ST_OK);
        add_row(WMAX, WMIN, WMIN + 1, WMAX - 1, WMAX, WMAX, WMAX, WMAX, WMAX,
                1, WMAX, ST_OK);
        add_row(-1, -1, -2, -3, -4, WMIN, 0, 0, 0, 1, WMIN, ST_OK);
        add_row(3, 1, 2, 3, 1, 5, 5, 5, 5, 1, 0, ST_COINC);

        foreach (stim_table[i])
            send_item(stim_table[i], $urandom_range(0, 3));

        for (int n = 0; n < 1000; n++)
        begin
            if (n == 500)
                long_hold = 1'b1;
            if ((n >= 500 && n < 800) || ((n / 100) % 3 == 1))
                send_item(random_row(), 0);
            else
                send_item(random_row(), $urandom_range(0, 13));
        end
        item_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (error_count == 0)
            $display("cubic_four_point_interpolation_top verification clean");
        else
            $display("cubic_four_point_interpolation_top verification failed");
        $finish;
    end

    initial
    begin
        int hold;
        int cnt;
        cnt = 0;
        result_stall = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (long_hold)
            begin
                hold = 600;
                long_hold = 1'b0;
            end
            else if ((cnt / 80) % 3 == 2)
                hold = 0;
            else
                hold = $urandom_range(0, 13);
            cnt++;
            if (hold > 0)
            begin
                result_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            result_stall <= 1'b0;
            do @(posedge clk); while (!result_valid);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        interp_result_t e;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected transfer y=%0d status=%0d",
                                          interp_y, status));
            else
            begin
                e = pending_results.pop_front();
                if (interp_y !== e.y)
                    report_mismatch($sformatf("interp_y %0d, want %0d", interp_y, e.y));
                if (status !== e.st)
                    report_mismatch($sformatf("status %0d, want %0d", status, e.st));
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("cubic_four_point_interpolation_top verification failed");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+src
src/cfp_pkg.sv
src/cfp_front.sv
src/cfp_mul.sv
src/cfp_prod.sv
src/cfp_div.sv
src/cubic_four_point_interpolation_top.sv
tb/sv/cubic_four_point_interpolation_top_test.sv
